### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, compiled out when ASSERT_OFF is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication under reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication under reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### hdl/tlfd_pkg.sv
// ---------------------------------------------------------------------------
// tlfd_pkg
// Types, tag constants and lookup functions for the frame deframer.
// ---------------------------------------------------------------------------
package tlfd_pkg;

  // Tag classes reported on results.
  typedef enum logic [2:0] {
    CLS_UNKNOWN = 3'd0,
    CLS_INFO    = 3'd1,
    CLS_DATR    = 3'd2,
    CLS_COMD    = 3'd3,
    CLS_QUIT    = 3'd4,
    CLS_COMS    = 3'd5,
    CLS_QUIS    = 3'd6,
    CLS_INFG    = 3'd7
  } frame_class_t;

  // Reply requests raised at frame end.
  typedef enum logic [1:0] {
    REPLY_NONE = 2'd0,
    REPLY_DATA = 2'd1,
    REPLY_QREL = 2'd2,
    REPLY_QUIT = 2'd3
  } reply_code_t;

  // Four-character ASCII tags, first character in the top byte.
  localparam logic [31:0] TAG_INFO = 32'h494E464F;
  localparam logic [31:0] TAG_DATR = 32'h44415452;
  localparam logic [31:0] TAG_COMD = 32'h434F4D44;
  localparam logic [31:0] TAG_QUIT = 32'h51554954;
  localparam logic [31:0] TAG_COMS = 32'h434F4D53;
  localparam logic [31:0] TAG_QUIS = 32'h51554953;
  localparam logic [31:0] TAG_INFG = 32'h494E4647;

  localparam int unsigned LEN_W   = 31;
  localparam int unsigned HDR_W   = 56;
  localparam logic [2:0]  HDR_LAST = 3'd7;

  // One result beat.
  typedef struct packed {
    logic              has_result;
    frame_class_t      frame_class;
    logic              header_done;
    logic [LEN_W-1:0]  body_length;
    logic              body_valid;
    logic [7:0]        body_data;
    logic              body_last;
    reply_code_t       reply_code;
  } tlfd_result_t;

  function automatic frame_class_t classify(input logic [31:0] tag);
    frame_class_t cls;
    unique case (tag)
      TAG_INFO: cls = CLS_INFO;
      TAG_DATR: cls = CLS_DATR;
      TAG_COMD: cls = CLS_COMD;
      TAG_QUIT: cls = CLS_QUIT;
      TAG_COMS: cls = CLS_COMS;
      TAG_QUIS: cls = CLS_QUIS;
      TAG_INFG: cls = CLS_INFG;
      default:  cls = CLS_UNKNOWN;
    endcase
    return cls;
  endfunction

  function automatic reply_code_t reply_for(input frame_class_t cls);
    reply_code_t rc;
    unique case (cls)
      CLS_DATR:          rc = REPLY_DATA;
      CLS_QUIT, CLS_QUIS: rc = REPLY_QREL;
      CLS_COMS:          rc = REPLY_QUIT;
      default:           rc = REPLY_NONE;
    endcase
    return rc;
  endfunction

endpackage

### hdl/tlfd_in_stage.sv
// ---------------------------------------------------------------------------
// tlfd_in_stage
// Input register: holds one received byte until the parser takes it.
// ---------------------------------------------------------------------------
module tlfd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       take,
  output logic       s1_valid,
  output logic [7:0] s1_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;

  // Space is free when empty or when the held beat leaves this cycle.
  assign in_ready  = !valid_r || take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;

endmodule

### hdl/tlfd_parser.sv
// ---------------------------------------------------------------------------
// tlfd_parser
// Frame state: header collector, body countdown and the per-beat result.
// ---------------------------------------------------------------------------
module tlfd_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  output tlfd_pkg::tlfd_result_t result
);

  logic [tlfd_pkg::HDR_W-1:0] hdr_shift_r, hdr_shift_nxt;
  logic [2:0]                 hdr_count_r, hdr_count_nxt;
  logic                       in_body_r, in_body_nxt;
  logic [tlfd_pkg::LEN_W-1:0] remaining_r, remaining_nxt;
  tlfd_pkg::frame_class_t     cls_r, cls_nxt;

  logic [31:0]                len_raw;
  logic [tlfd_pkg::LEN_W-1:0] len_eff;
  tlfd_pkg::frame_class_t     hdr_cls;
  logic                       body_end;

  // Header fields as they stand when the eighth byte arrives.
  assign len_raw  = {hdr_shift_r[23:0], rx_byte};
  assign len_eff  = len_raw[31] ? '0 : len_raw[tlfd_pkg::LEN_W-1:0];
  assign hdr_cls  = tlfd_pkg::classify(hdr_shift_r[55:24]);
  assign body_end = (remaining_r <= tlfd_pkg::LEN_W'(1));

  // Next state and result for the beat at the head of the input register.
  always_comb begin
    hdr_shift_nxt = hdr_shift_r;
    hdr_count_nxt = hdr_count_r;
    in_body_nxt   = in_body_r;
    remaining_nxt = remaining_r;
    cls_nxt       = cls_r;
    result        = '0;
    if (in_body_r) begin
      result.has_result  = 1'b1;
      result.frame_class = cls_r;
      result.body_valid  = 1'b1;
      result.body_data   = rx_byte;
      result.body_last   = body_end;
      result.reply_code  = body_end ? tlfd_pkg::reply_for(cls_r) : tlfd_pkg::REPLY_NONE;
      if (body_end) begin
        in_body_nxt   = 1'b0;
        remaining_nxt = '0;
      end else begin
        remaining_nxt = remaining_r - tlfd_pkg::LEN_W'(1);
      end
    end else if (hdr_count_r != tlfd_pkg::HDR_LAST) begin
      hdr_shift_nxt = {hdr_shift_r[tlfd_pkg::HDR_W-9:0], rx_byte};
      hdr_count_nxt = hdr_count_r + 3'd1;
    end else begin
      hdr_shift_nxt      = '0;
      hdr_count_nxt      = '0;
      cls_nxt            = hdr_cls;
      result.has_result  = 1'b1;
      result.frame_class = hdr_cls;
      result.header_done = 1'b1;
      result.body_length = len_eff;
      if (len_eff == '0) begin
        in_body_nxt       = 1'b0;
        remaining_nxt     = '0;
        result.reply_code = tlfd_pkg::reply_for(hdr_cls);
      end else begin
        in_body_nxt   = 1'b1;
        remaining_nxt = len_eff;
      end
    end
  end

  // State advances only when a beat is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_shift_r <= '0;
      hdr_count_r <= '0;
      in_body_r   <= 1'b0;
      remaining_r <= '0;
      cls_r       <= tlfd_pkg::CLS_UNKNOWN;
    end else if (step) begin
      hdr_shift_r <= hdr_shift_nxt;
      hdr_count_r <= hdr_count_nxt;
      in_body_r   <= in_body_nxt;
      remaining_r <= remaining_nxt;
      cls_r       <= cls_nxt;
    end
  end

endmodule

### hdl/tlfd_out_stage.sv
// ---------------------------------------------------------------------------
// tlfd_out_stage
// Result register: holds one result beat until the sink takes it.
// ---------------------------------------------------------------------------
module tlfd_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  tlfd_pkg::tlfd_result_t result,
  output logic                   can_take,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tlfd_pkg::tlfd_result_t out_beat
);

  logic                   valid_r, valid_nxt;
  tlfd_pkg::tlfd_result_t beat_r;

  // A new beat may enter when the register is empty or being emptied.
  assign can_take = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (step) begin
      valid_nxt = result.has_result;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result.has_result) begin
      beat_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_beat  = beat_r;

endmodule

### hdl/tagged_length_frame_deframer.sv
// ---------------------------------------------------------------------------
// tagged_length_frame_deframer
// Splits a byte stream of tag/length/body frames into header and body beats.
//
//   Channel   Direction  Payload                                  Handshake
//   in_       input      in_rx_byte                               valid/ready
//   out_      output     class, header, length, body, reply code  valid/ready
//
// One byte is taken per cycle while the sink is not stalled; each byte is held in
// the input register, then its result is registered in the result register.
// Header bytes one to seven yield no result beat.
// Reset (rst_n low, synchronous) clears the frame state and empties both stages.
// A stalled sink holds the result register; the input register fills behind it.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tagged_length_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_frame_class,
  output logic        out_header_done,
  output logic [30:0] out_body_length,
  output logic        out_body_valid,
  output logic [7:0]  out_body_data,
  output logic        out_body_last,
  output logic [1:0]  out_reply_code
);

  logic                   s1_valid;
  logic [7:0]             s1_byte;
  logic                   can_take;
  logic                   step;
  tlfd_pkg::tlfd_result_t result;
  tlfd_pkg::tlfd_result_t out_beat;

  // A held byte is processed whenever the result register can accept.
  assign step = s1_valid && can_take;

  tlfd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .take       (step),
    .s1_valid   (s1_valid),
    .s1_byte    (s1_byte)
  );

  tlfd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (s1_byte),
    .result  (result)
  );

  tlfd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .result    (result),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  // Result fields to ports.
  assign out_frame_class = out_beat.frame_class;
  assign out_header_done = out_beat.header_done;
  assign out_body_length = out_beat.body_length;
  assign out_body_valid  = out_beat.body_valid;
  assign out_body_data   = out_beat.body_data;
  assign out_body_last   = out_beat.body_last;
  assign out_reply_code  = out_beat.reply_code;

  // Terms used by the checks below.
  logic one_kind;
  logic body_beat;
  logic len_zero;
  logic has_reply;
  logic at_frame_end;

  assign one_kind     = out_header_done ^ out_body_valid;
  assign body_beat    = out_valid && out_body_valid;
  assign len_zero     = (out_body_length == 31'd0);
  assign has_reply    = out_valid && (out_reply_code != tlfd_pkg::REPLY_NONE);
  assign at_frame_end = out_body_last || (out_header_done && len_zero);

  // A beat is either a header beat or a body beat, never both.
  `ASSERT_IMPLY(a_hdr_xor_body, clk, rst_n, out_valid, one_kind, "beat kind unclear")
  // Replies are requested only where a frame ends.
  `ASSERT_IMPLY(a_reply_at_end, clk, rst_n, has_reply, at_frame_end, "reply outside frame end")
  // Body beats carry no length.
  `ASSERT_IMPLY(a_body_no_len, clk, rst_n, body_beat, len_zero, "length on a body beat")
  // A processed byte with a result always leaves a valid result beat.
  `ASSERT_NEXT(a_step_fills, clk, rst_n, step && result.has_result, out_valid, "result beat lost")

endmodule
